// ===== design/u8se_pkg.sv =====
// Package for the UTF-8 text run extractor: beat types and byte class constants.
// No dependencies; used by utf8_string_extractor.
`default_nettype none

package u8se_pkg;

    // One input beat: a raw image byte and the last-byte mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_image;
    } item_beat_t;

    // One result beat: where the text run starts and how long it is.
    typedef struct packed {
        logic [31:0] run_offset;
        logic [31:0] run_length;
    } result_beat_t;

    // Byte class boundaries.
    localparam logic [7:0] NUL_BYTE       = 8'h00;
    localparam logic [7:0] LEAD3_LO       = 8'hE0;
    localparam logic [7:0] LEAD3_HI       = 8'hEF;
    localparam logic [7:0] LEAD2_LO       = 8'hC0;
    localparam logic [7:0] LEAD2_HI       = 8'hDF;
    localparam logic [7:0] CONT_LO        = 8'h80;
    localparam logic [7:0] CONT_HI        = 8'hBF;
    localparam logic [7:0] PRINTABLE_LO   = 8'h20;
    localparam logic [7:0] CR_BYTE        = 8'h0D;
    localparam logic [7:0] LF_BYTE        = 8'h0A;

    // Continuations owed after a lead byte.
    localparam logic [1:0] CONT_NONE      = 2'd0;
    localparam logic [1:0] CONT_ONE       = 2'd1;
    localparam logic [1:0] CONT_TWO       = 2'd2;

endpackage : u8se_pkg

`default_nettype wire

// ===== design/utf8_string_extractor.sv =====
// UTF-8 text run extractor top level: input register, byte decode, result register.
// Depends on u8se_pkg for the beat types and byte class constants.
`default_nettype none

// The block takes one image byte per cycle while item_stall is low and
// reports each NUL-terminated run of printable ASCII, CR, LF and
// well-formed two- and three-byte UTF-8 sequences as a start offset and a
// byte length. A byte is held in the input register, where the decode and
// counter update run, and its result, if any, is loaded into the result
// register when the byte leaves the input register. The input stalls only
// when the byte in the input register ends a run that is reported while the
// result register still holds a beat that is stalled.
// With include_ascii_only at 0 only runs holding a multibyte sequence are
// reported. Offsets count from the first byte after reset or after a beat
// marked end_of_image; the position counter is POSITION_BITS wide and the
// offset is its low 32 bits (zero-extended when narrower).
module utf8_string_extractor
    import u8se_pkg::*;
#(
    parameter int POSITION_BITS = 32
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Configuration write.
    input  wire logic         cfg_write,
    input  wire logic         cfg_data,
    // Byte channel.
    input  wire logic         item_valid,
    output logic              item_stall,
    input  wire item_beat_t   item,
    // Result channel.
    output logic              result_valid,
    input  wire logic         result_stall,
    output result_beat_t      result
);

    // Configuration and input stage registers.
    logic                     include_ascii_only_reg;
    logic                     stage_valid_reg;
    item_beat_t               stage_reg;

    // Scanner state.
    logic [POSITION_BITS-1:0] position_reg, position_next;
    logic                     active_reg, active_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [31:0]              bytes_reg, bytes_next;
    logic [1:0]               cont_due_reg, cont_due_next;
    logic                     saw_multi_reg, saw_multi_next;

    // Result register.
    logic                     result_valid_reg;
    result_beat_t             result_reg;

    // Decode outputs and handshake.
    logic                     emit;
    result_beat_t             emit_beat;
    logic                     out_free;
    logic                     stage_advance;
    logic                     item_accept;

    // Byte decode and state update for the beat in the input register.
    always_comb
    begin
        logic [7:0] b;
        logic       handled;
        b              = stage_reg.data_byte;
        handled        = 1'b0;
        position_next  = position_reg;
        active_next    = active_reg;
        start_next     = start_reg;
        bytes_next     = bytes_reg;
        cont_due_next  = cont_due_reg;
        saw_multi_next = saw_multi_reg;
        emit           = 1'b0;
        emit_beat      = '0;

        // A continuation byte is owed: take it or abort the run.
        if (cont_due_reg != CONT_NONE)
        begin
            if (b >= CONT_LO && b <= CONT_HI)
            begin
                bytes_next    = bytes_reg + 32'd1;
                cont_due_next = cont_due_reg - 2'd1;
                handled       = 1'b1;
            end
            else
            begin
                active_next    = 1'b0;
                start_next     = '0;
                bytes_next     = '0;
                cont_due_next  = CONT_NONE;
                saw_multi_next = 1'b0;
            end
        end

        // Otherwise the byte is classed as a fresh character.
        if (!handled)
        begin
            priority if (b == NUL_BYTE)
            begin
                emit = active_next && (include_ascii_only_reg || saw_multi_next);
                emit_beat.run_offset = 32'(start_next);
                emit_beat.run_length = bytes_next;
                active_next    = 1'b0;
                start_next     = '0;
                bytes_next     = '0;
                cont_due_next  = CONT_NONE;
                saw_multi_next = 1'b0;
            end
            else if ((b >= LEAD2_LO && b <= LEAD3_HI) || b < CONT_LO
                     || b == CR_BYTE || b == LF_BYTE)
            begin
                // Printable ASCII, CR, LF and lead bytes extend or open a run;
                // control bytes are caught just below.
                if (b < PRINTABLE_LO && b != CR_BYTE && b != LF_BYTE)
                begin
                    active_next    = 1'b0;
                    start_next     = '0;
                    bytes_next     = '0;
                    cont_due_next  = CONT_NONE;
                    saw_multi_next = 1'b0;
                end
                else
                begin
                    if (!active_next)
                    begin
                        active_next    = 1'b1;
                        start_next     = position_reg;
                        bytes_next     = '0;
                        saw_multi_next = 1'b0;
                    end
                    bytes_next = bytes_next + 32'd1;
                    if (b >= LEAD3_LO)
                    begin
                        saw_multi_next = 1'b1;
                        cont_due_next  = CONT_TWO;
                    end
                    else if (b >= LEAD2_LO)
                    begin
                        saw_multi_next = 1'b1;
                        cont_due_next  = CONT_ONE;
                    end
                end
            end
            else
            begin
                // Stray continuation byte.
                active_next    = 1'b0;
                start_next     = '0;
                bytes_next     = '0;
                cont_due_next  = CONT_NONE;
                saw_multi_next = 1'b0;
            end
        end

        // Advance the position; the last byte of an image clears everything.
        position_next = position_reg + POSITION_BITS'(1);
        if (stage_reg.end_of_image)
        begin
            position_next  = '0;
            active_next    = 1'b0;
            start_next     = '0;
            bytes_next     = '0;
            cont_due_next  = CONT_NONE;
            saw_multi_next = 1'b0;
        end
    end

    // Handshake: the input stage moves on unless its result has nowhere to go.
    assign out_free      = !result_valid_reg || !result_stall;
    assign stage_advance = stage_valid_reg && (!emit || out_free);
    assign item_stall    = stage_valid_reg && !stage_advance;
    assign item_accept   = item_valid && !item_stall;

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            include_ascii_only_reg <= 1'b0;
            stage_valid_reg        <= 1'b0;
            result_valid_reg       <= 1'b0;
            position_reg           <= '0;
            active_reg             <= 1'b0;
            start_reg              <= '0;
            bytes_reg              <= '0;
            cont_due_reg           <= CONT_NONE;
            saw_multi_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                include_ascii_only_reg <= cfg_data;
            end

            if (item_accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (stage_advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (stage_advance)
            begin
                position_reg  <= position_next;
                active_reg    <= active_next;
                start_reg     <= start_next;
                bytes_reg     <= bytes_next;
                cont_due_reg  <= cont_due_next;
                saw_multi_reg <= saw_multi_next;
            end

            if (stage_advance && emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            stage_reg <= item;
        end
        if (stage_advance && emit)
        begin
            result_reg <= emit_beat;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A sequence can never owe three continuations.
    assert property (@(posedge clk) disable iff (!rst_n)
        cont_due_reg != 2'd3)
        else $error("continuation count out of range");

    // With no open run, the run counters sit at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (bytes_reg == '0 && cont_due_reg == CONT_NONE && !saw_multi_reg))
        else $error("run counters set without an open run");

    // Owed continuations only inside an open multibyte run.
    assert property (@(posedge clk) disable iff (!rst_n)
        cont_due_reg != CONT_NONE |-> (active_reg && saw_multi_reg))
        else $error("continuations owed outside a multibyte run");

    // A pending result with a full, stalled result register holds the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && emit && result_valid_reg && result_stall) |-> item_stall)
        else $error("result would be overwritten");

    // After the last byte of an image the position and run are cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_advance && stage_reg.end_of_image) |=> (position_reg == '0 && !active_reg))
        else $error("image end did not clear the scanner");

endmodule : utf8_string_extractor

`default_nettype wire
